// ===== rtl/three_phase_srf_pll_unit_macros.svh =====
// Assertion macros for the synchronous reference frame PLL unit.
// Used by the top level; no other dependencies.
`ifndef THREE_PHASE_SRF_PLL_UNIT_MACROS_SVH
`define THREE_PHASE_SRF_PLL_UNIT_MACROS_SVH

`ifndef SYNTH
`define SRF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("srf assertion failed");
`define SRF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("srf assertion failed");
`else
`define SRF_ASSERT_IMPL(label, ante, cons)
`define SRF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/srf_pkg.sv =====
// Shared types, constants and the sine table generator for the SRF PLL unit.
// No dependencies.
package srf_pkg;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SMP_W  = 16;
   localparam int DQ_W   = 18;
   localparam int ANG_W  = 32;
   localparam int FREQ_W = 32;
   localparam int INTEG_W = 48;

   localparam logic [16:0] INV_SQRT3_Q16 = 17'd37837;

   localparam longint unsigned SIN_C1 = 64'd1686629713;
   localparam longint unsigned SIN_C3 = 64'd693598668;
   localparam longint unsigned SIN_C5 = 64'd85569305;
   localparam longint unsigned SIN_C7 = 64'd5026995;
   localparam longint unsigned SIN_C9 = 64'd172272;

   typedef enum logic [2:0] {
      REG_KP_GAIN   = 3'd0,
      REG_KI_GAIN   = 3'd1,
      REG_NOMINAL   = 3'd2,
      REG_TIME_STEP = 3'd3,
      REG_INT_LIMIT = 3'd4
   } csr_reg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_BETA, ST_D1, ST_D2, ST_D3, ST_Q1, ST_Q2,
      ST_I1, ST_I2, ST_I3, ST_I4, ST_K1, ST_K2, ST_K3,
      ST_F1, ST_F2, ST_F3
   } seq_state_type;

   typedef struct packed {
      logic                    en;
      logic signed [MUL_W-1:0] op_a;
      logic signed [MUL_W-1:0] op_b;
   } mul_req_type;

   // Quarter-wave odd polynomial evaluated with unsigned Horner steps.
   function automatic logic signed [SMP_W-1:0] sine_entry(int unsigned idx,
                                                           int unsigned bits);
      longint unsigned qb;
      longint unsigned quad;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned p;
      longint unsigned s30;
      longint unsigned val;
      qb   = 64'(bits) - 64'd2;
      quad = (64'(idx) >> qb) & 64'd3;
      r    = 64'(idx) & ((64'd1 << qb) - 64'd1);
      x    = r << (64'd30 - qb);
      if (quad[0]) begin
         x = (64'd1 << 30) - x;
      end
      x2  = (x * x) >> 30;
      p   = SIN_C7 - ((x2 * SIN_C9) >> 30);
      p   = SIN_C5 - ((x2 * p) >> 30);
      p   = SIN_C3 - ((x2 * p) >> 30);
      p   = SIN_C1 - ((x2 * p) >> 30);
      s30 = (x * p) >> 30;
      val = (s30 + (64'd1 << 14)) >> 15;
      if (val > 64'd32767) begin
         val = 64'd32767;
      end
      if (quad >= 64'd2) begin
         return -SMP_W'(val);
      end
      return SMP_W'(val);
   endfunction

endpackage

// ===== rtl/srf_sine_rom.sv =====
// Sine lookup table with a registered read port for the SRF PLL unit.
// Depends on srf_pkg for the table generator.
module srf_sine_rom
   import srf_pkg::*;
#(
   parameter int TABLE_BITS = 10
) (
   input  logic                           clock,
   input  logic [TABLE_BITS-1:0]          addr,
   output logic signed [SMP_W-1:0]        data_ff
);

   localparam int DEPTH = 1 << TABLE_BITS;

   logic signed [SMP_W-1:0] rom_table [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_rom
      assign rom_table[i] = sine_entry(i, TABLE_BITS);
   end

   always_ff @(posedge clock) begin
      data_ff <= rom_table[addr];
   end

endmodule

// ===== rtl/srf_mul.sv =====
// Shared signed multiplier with a registered product for the SRF PLL unit.
// Depends on srf_pkg for the request struct and widths.
module srf_mul
   import srf_pkg::*;
(
   input  logic                      clock,
   input  mul_req_type               req,
   output logic signed [PROD_W-1:0]  prod_ff
);

   always_ff @(posedge clock) begin
      if (req.en) begin
         prod_ff <= PROD_W'(req.op_a) * PROD_W'(req.op_b);
      end
   end

endmodule

// ===== rtl/three_phase_srf_pll_unit.sv =====
// Synchronous reference frame PLL: one three-phase sample in, one phase/frequency item out.
// A new sample is accepted only in the idle state, after the previous item leaves the last step.
// Sixteen sequencer steps share one 33x33 multiplier for all ten products, plus the idle state.
// The result register frees the input side; only the last step stalls while a result waits.
// Synchronous active-high reset clears phase and integral and loads register defaults.
// Depends on srf_pkg, srf_sine_rom, srf_mul and the assertion macros header.
`include "three_phase_srf_pll_unit_macros.svh"

module three_phase_srf_pll_unit
   import srf_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [47:0]   req_tdata,    // phase_a, phase_b, phase_c
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,    // phase_angle, frequency, direct_component,
                                       // quadrature_component, zero pad
   output logic          rsp_tuser,    // frequency_saturated
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   localparam int PHASE_PAD = ANG_W - PHASE_BITS;
   localparam logic [SINE_TABLE_BITS-1:0] QUARTER =
      SINE_TABLE_BITS'(1 << (SINE_TABLE_BITS - 2));

   seq_state_type state_ff, state_in;

   logic [23:0] kp_ff, ki_ff;
   logic [30:0] nom_ff;
   logic [31:0] ts_ff;
   logic [15:0] lim_ff;

   logic [PHASE_BITS-1:0]      phase_ff, phase_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;

   logic signed [SMP_W-1:0]    a_ff, a_in;
   logic signed [16:0]         diff_ff, diff_in;
   logic signed [17:0]         beta_ff, beta_in;
   logic signed [SMP_W-1:0]    sn_ff, sn_in, cs_ff, cs_in;
   logic signed [PROD_W-1:0]   acc_ff, acc_in;
   logic signed [DQ_W-1:0]     d_ff, d_in, q_ff, q_in;
   logic signed [48:0]         isum_ff, isum_in;
   logic signed [35:0]         prop_ff, prop_in;
   logic signed [38:0]         ir_ff, ir_in;
   logic signed [49:0]         kit_ff, kit_in;
   logic signed [FREQ_W-1:0]   freq_ff, freq_in;
   logic                       sat_ff, sat_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ANG_W-1:0]           rsp_phase_ff, rsp_phase_in;
   logic [FREQ_W-1:0]          rsp_freq_ff, rsp_freq_in;
   logic [DQ_W-1:0]            rsp_d_ff, rsp_d_in, rsp_q_ff, rsp_q_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   mul_req_type                mul_req;
   logic signed [PROD_W-1:0]   prod;
   logic [SINE_TABLE_BITS-1:0] rom_addr;
   logic signed [SMP_W-1:0]    rom_q;

   logic [ANG_W-1:0]           phase_full;
   logic [SINE_TABLE_BITS-1:0] sin_idx;
   logic signed [PROD_W-1:0]   beta_rnd, dsum, qsum, irnd, prnd, ksum, drnd;
   logic signed [18:0]         err_w;
   logic signed [48:0]         lim49, irsum;
   logic signed [50:0]         fsum;
   logic signed [MUL_W-1:0]    ts33, kp33, ki33;
   logic                       accept, out_free, csr_wr;
   csr_reg_type                csr_idx;

   srf_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .data_ff (rom_q)
   );

   srf_mul u_mul (
      .clock   (clock),
      .req     (mul_req),
      .prod_ff (prod)
   );

   assign phase_full = ANG_W'(phase_ff) << PHASE_PAD;
   assign sin_idx    = phase_full[ANG_W-1 -: SINE_TABLE_BITS];
   assign rom_addr   = (state_ff == ST_IDLE) ? sin_idx : sin_idx + QUARTER;

   assign beta_rnd = prod + 66'sd32768;
   assign dsum     = acc_ff + prod + 66'sd16384;
   assign qsum     = acc_ff - prod + 66'sd16384;
   assign irnd     = prod + 66'sd65536;
   assign prnd     = prod + 66'sd64;
   assign ksum     = acc_ff + (prod <<< 20) + 66'sd8192;
   assign drnd     = prod + 66'sd32768;
   assign err_w    = -(19'(q_ff));
   assign lim49    = signed'({3'b000, lim_ff, 30'd0});
   assign irsum    = 49'(integ_ff) + 49'sd128;
   assign fsum     = 51'(signed'({1'b0, nom_ff})) + 51'(prop_ff) + 51'(kit_ff);
   assign ts33     = signed'({1'b0, ts_ff});
   assign kp33     = 33'(signed'({1'b0, kp_ff}));
   assign ki33     = 33'(signed'({1'b0, ki_ff}));

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         integ_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         integ_ff     <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      diff_ff      <= diff_in;
      beta_ff      <= beta_in;
      sn_ff        <= sn_in;
      cs_ff        <= cs_in;
      acc_ff       <= acc_in;
      d_ff         <= d_in;
      q_ff         <= q_in;
      isum_ff      <= isum_in;
      prop_ff      <= prop_in;
      ir_ff        <= ir_in;
      kit_ff       <= kit_in;
      freq_ff      <= freq_in;
      sat_ff       <= sat_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_freq_ff  <= rsp_freq_in;
      rsp_d_ff     <= rsp_d_in;
      rsp_q_ff     <= rsp_q_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      integ_in     = integ_ff;
      a_in         = a_ff;
      diff_in      = diff_ff;
      beta_in      = beta_ff;
      sn_in        = sn_ff;
      cs_in        = cs_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      q_in         = q_ff;
      isum_in      = isum_ff;
      prop_in      = prop_ff;
      ir_in        = ir_ff;
      kit_in       = kit_ff;
      freq_in      = freq_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_phase_in = rsp_phase_ff;
      rsp_freq_in  = rsp_freq_ff;
      rsp_d_in     = rsp_d_ff;
      rsp_q_in     = rsp_q_ff;
      rsp_sat_in   = rsp_sat_ff;
      mul_req      = '{en: 1'b0, op_a: '0, op_b: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in     = signed'(req_tdata[15:0]);
               diff_in  = 17'(signed'(req_tdata[31:16])) - 17'(signed'(req_tdata[47:32]));
               state_in = ST_BETA;
            end
         end
         ST_BETA: begin
            mul_req  = '{en: 1'b1, op_a: 33'(diff_ff),
                         op_b: 33'(signed'({1'b0, INV_SQRT3_Q16}))};
            sn_in    = rom_q;
            state_in = ST_D1;
         end
         ST_D1: begin
            beta_in  = beta_rnd[33:16];
            cs_in    = rom_q;
            mul_req  = '{en: 1'b1, op_a: 33'(a_ff), op_b: 33'(rom_q)};
            state_in = ST_D2;
         end
         ST_D2: begin
            acc_in   = prod;
            mul_req  = '{en: 1'b1, op_a: 33'(beta_ff), op_b: 33'(sn_ff)};
            state_in = ST_D3;
         end
         ST_D3: begin
            d_in     = dsum[32:15];
            mul_req  = '{en: 1'b1, op_a: 33'(beta_ff), op_b: 33'(cs_ff)};
            state_in = ST_Q1;
         end
         ST_Q1: begin
            acc_in   = prod;
            mul_req  = '{en: 1'b1, op_a: 33'(a_ff), op_b: 33'(sn_ff)};
            state_in = ST_Q2;
         end
         ST_Q2: begin
            q_in     = qsum[32:15];
            state_in = ST_I1;
         end
         ST_I1: begin
            mul_req  = '{en: 1'b1, op_a: 33'(err_w), op_b: ts33};
            state_in = ST_I2;
         end
         ST_I2: begin
            isum_in  = 49'(integ_ff) + signed'(irnd[65:17]);
            mul_req  = '{en: 1'b1, op_a: kp33, op_b: 33'(err_w)};
            state_in = ST_I3;
         end
         ST_I3: begin
            prop_in = prnd[42:7];
            if (isum_ff > lim49) begin
               integ_in = 48'(lim49);
            end else if (isum_ff < -lim49) begin
               integ_in = 48'(-lim49);
            end else begin
               integ_in = 48'(isum_ff);
            end
            state_in = ST_I4;
         end
         ST_I4: begin
            ir_in    = irsum[46:8];
            state_in = ST_K1;
         end
         ST_K1: begin
            mul_req  = '{en: 1'b1, op_a: ki33, op_b: 33'(signed'({1'b0, ir_ff[19:0]}))};
            state_in = ST_K2;
         end
         ST_K2: begin
            acc_in   = prod;
            mul_req  = '{en: 1'b1, op_a: ki33, op_b: 33'(signed'(ir_ff[38:20]))};
            state_in = ST_K3;
         end
         ST_K3: begin
            kit_in   = ksum[63:14];
            state_in = ST_F1;
         end
         ST_F1: begin
            if (fsum > 51'sd2147483647) begin
               freq_in = 32'sh7FFFFFFF;
               sat_in  = 1'b1;
            end else if (fsum < -51'sd2147483648) begin
               freq_in = 32'sh80000000;
               sat_in  = 1'b1;
            end else begin
               freq_in = fsum[31:0];
               sat_in  = 1'b0;
            end
            state_in = ST_F2;
         end
         ST_F2: begin
            mul_req  = '{en: 1'b1, op_a: 33'(freq_ff), op_b: ts33};
            state_in = ST_F3;
         end
         ST_F3: begin
            if (out_free) begin
               phase_in     = PHASE_BITS'((phase_full + drnd[47:16]) >> PHASE_PAD);
               rsp_valid_in = 1'b1;
               rsp_phase_in = (phase_full + drnd[47:16]) >> PHASE_PAD << PHASE_PAD;
               rsp_freq_in  = freq_ff;
               rsp_d_in     = d_ff;
               rsp_q_in     = q_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_q_ff, rsp_d_ff, rsp_freq_ff, rsp_phase_ff};
   assign rsp_tuser  = rsp_sat_ff;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_reg_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= 24'd25600;
         ki_ff  <= 24'd256000;
         nom_ff <= 31'd3276800;
         ts_ff  <= 32'd4294967;
         lim_ff <= 16'd1000;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_KP_GAIN:   kp_ff  <= csr_pwdata[23:0];
            REG_KI_GAIN:   ki_ff  <= csr_pwdata[23:0];
            REG_NOMINAL:   nom_ff <= csr_pwdata[30:0];
            REG_TIME_STEP: ts_ff  <= csr_pwdata;
            REG_INT_LIMIT: lim_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_KP_GAIN:   csr_prdata = 32'(kp_ff);
         REG_KI_GAIN:   csr_prdata = 32'(ki_ff);
         REG_NOMINAL:   csr_prdata = 32'(nom_ff);
         REG_TIME_STEP: csr_prdata = ts_ff;
         REG_INT_LIMIT: csr_prdata = 32'(lim_ff);
         default:       csr_prdata = '0;
      endcase
   end

   `SRF_ASSERT_NEXT(a_accept_starts, accept, state_ff == ST_BETA && !req_tready)
   `SRF_ASSERT_IMPL(a_rsp_from_last_step, $rose(rsp_tvalid), $past(state_ff == ST_F3))
   `SRF_ASSERT_NEXT(a_prod_held_on_stall, state_ff == ST_F3 && !out_free,
                    $stable(prod) && state_ff == ST_F3)

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for three_phase_srf_pll_unit: sends three-phase samples on the request
// stream, programs the loop over APB and checks every result against a local loop model.
// Depends on srf_pkg and the unit's RTL.
module testbench;
   import srf_pkg::*;

   localparam int TABLE_BITS = 10;
   localparam int TABLE_SIZE = 1 << TABLE_BITS;
   localparam int QUARTER = TABLE_SIZE / 4;
   localparam int THIRD = TABLE_SIZE / 3;
   localparam longint INV_SQRT3 = 37837;
   localparam longint unsigned TAYLOR_1 = 64'd1686629713;
   localparam longint unsigned TAYLOR_3 = 64'd693598668;
   localparam longint unsigned TAYLOR_5 = 64'd85569305;
   localparam longint unsigned TAYLOR_7 = 64'd5026995;
   localparam longint unsigned TAYLOR_9 = 64'd172272;
   localparam logic [2:0] UNMAPPED_REG = 3'd5;
   localparam int READY_ALWAYS = 0;
   localparam int READY_RANDOM = 1;
   localparam int READY_PATTERN = 2;
   localparam int DRAIN_CYCLES = 40;

   // Packed so that phase_a lands in the lowest bits of req_tdata.
   typedef struct packed {
      logic signed [15:0] phase_c;
      logic signed [15:0] phase_b;
      logic signed [15:0] phase_a;
   } sample_t;

   typedef struct packed {
      logic        saturated;
      logic [17:0] quadrature;
      logic [17:0] direct;
      logic [31:0] frequency;
      logic [31:0] phase_angle;
   } loop_result_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   three_phase_srf_pll_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [15:0] sine_lut [TABLE_SIZE];
   longint      cfg_kp = 25600;
   longint      cfg_ki = 256000;
   longint      cfg_nominal = 3276800;
   longint      cfg_step = 4294967;
   longint      cfg_limit = 1000;
   logic [31:0] loop_phase = '0;
   longint      loop_integral = 0;
   loop_result_t pending_loop_results [$];
   int          fail_count = 0;

   int          sender_gap_max = 0;
   int          burst_left = 0;
   int          ready_mode = READY_ALWAYS;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_length = 0;
   int          hold_left = 0;
   int          pattern_count = 0;

   logic [31:0] wave_phase = '0;
   logic [31:0] wave_step = '0;
   longint      wave_amp = 20000;
   longint      wave_noise = 0;

   function automatic logic signed [15:0] poly_sine(int unsigned index);
      longint unsigned frac;
      longint unsigned sq;
      longint unsigned acc;
      longint unsigned mag;
      int unsigned     quadrant;
      quadrant = index >> (TABLE_BITS - 2);
      frac = longint'(index & (QUARTER - 1)) << (30 - (TABLE_BITS - 2));
      if ((quadrant & 1) != 0) begin
         frac = (64'd1 << 30) - frac;
      end
      sq = (frac * frac) >> 30;
      acc = TAYLOR_7 - ((sq * TAYLOR_9) >> 30);
      acc = TAYLOR_5 - ((sq * acc) >> 30);
      acc = TAYLOR_3 - ((sq * acc) >> 30);
      acc = TAYLOR_1 - ((sq * acc) >> 30);
      mag = (((frac * acc) >> 30) + (64'd1 << 14)) >> 15;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return (quadrant >= 2) ? -16'(mag) : 16'(mag);
   endfunction

   function automatic longint round_shift(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic loop_result_t advance_loop(sample_t s);
      longint       a;
      longint       b;
      longint       c;
      longint       beta;
      longint       sn;
      longint       cs;
      longint       d;
      longint       q;
      longint       err;
      longint       lim;
      longint       freq;
      longint       delta;
      int unsigned  idx;
      loop_result_t r;
      a = s.phase_a;
      b = s.phase_b;
      c = s.phase_c;
      beta = round_shift((b - c) * INV_SQRT3, 16);
      idx = loop_phase[31:32-TABLE_BITS];
      sn = sine_lut[idx];
      cs = sine_lut[(idx + QUARTER) % TABLE_SIZE];
      d = round_shift(a * cs + beta * sn, 15);
      q = round_shift(beta * cs - a * sn, 15);
      err = -q;
      lim = cfg_limit * (longint'(1) << 30);
      loop_integral = loop_integral + round_shift(err * cfg_step, 17);
      if (loop_integral > lim) begin
         loop_integral = lim;
      end
      if (loop_integral < -lim) begin
         loop_integral = -lim;
      end
      freq = cfg_nominal + round_shift(cfg_kp * err, 7)
           + round_shift(cfg_ki * round_shift(loop_integral, 8), 14);
      r.saturated = 1'b0;
      if (freq > 64'sd2147483647) begin
         freq = 64'sd2147483647;
         r.saturated = 1'b1;
      end
      if (freq < -64'sd2147483648) begin
         freq = -64'sd2147483648;
         r.saturated = 1'b1;
      end
      delta = round_shift(freq * cfg_step, 16);
      loop_phase = loop_phase + delta[31:0];
      r.phase_angle = loop_phase;
      r.frequency = freq[31:0];
      r.direct = d[17:0];
      r.quadrature = q[17:0];
      return r;
   endfunction

   function automatic void apply_register(logic [2:0] index, logic [31:0] value);
      case (index)
         REG_KP_GAIN:   cfg_kp = longint'(value[23:0]);
         REG_KI_GAIN:   cfg_ki = longint'(value[23:0]);
         REG_NOMINAL:   cfg_nominal = longint'(value[30:0]);
         REG_TIME_STEP: cfg_step = longint'(value);
         REG_INT_LIMIT: cfg_limit = longint'(value[15:0]);
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] register_value(logic [2:0] index);
      case (index)
         REG_KP_GAIN:   return 32'(cfg_kp);
         REG_KI_GAIN:   return 32'(cfg_ki);
         REG_NOMINAL:   return 32'(cfg_nominal);
         REG_TIME_STEP: return 32'(cfg_step);
         default:       return 32'(cfg_limit);
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function automatic sample_t make_sample(int a, int b, int c);
      sample_t s;
      s.phase_a = 16'(a);
      s.phase_b = 16'(b);
      s.phase_c = 16'(c);
      return s;
   endfunction

   function automatic logic signed [15:0] grid_value(int unsigned index);
      longint v;
      v = (wave_amp * longint'(sine_lut[index])) >>> 15;
      v = v + longint'($urandom_range(0, 32'(2 * wave_noise))) - wave_noise;
      if (v > 32767) begin
         v = 32767;
      end
      if (v < -32768) begin
         v = -32768;
      end
      return 16'(v);
   endfunction

   function automatic sample_t grid_sample();
      sample_t     s;
      int unsigned idx;
      idx = wave_phase[31:32-TABLE_BITS];
      s.phase_a = grid_value(idx);
      s.phase_b = grid_value((idx + TABLE_SIZE - THIRD) % TABLE_SIZE);
      s.phase_c = grid_value((idx + THIRD) % TABLE_SIZE);
      wave_phase = wave_phase + wave_step;
      return s;
   endfunction

   // Result checker: every accepted item is compared with the oldest prediction.
   always @(posedge clock) begin : check_results
      loop_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_loop_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_loop_results.pop_front();
            check_field("phase_angle", want.phase_angle, rsp_tdata[31:0]);
            check_field("frequency", want.frequency, rsp_tdata[63:32]);
            check_field("direct_component", 32'(want.direct), 32'(rsp_tdata[81:64]));
            check_field("quadrature_component", 32'(want.quadrature), 32'(rsp_tdata[99:82]));
            check_field("frequency_saturated", 32'(want.saturated), 32'(rsp_tuser));
         end
      end
   end

   // Receiver: a long hold-off when one is requested, else the current stall pattern.
   always @(negedge clock) begin
      pattern_count <= pattern_count + 1;
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= hold_length;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
            READY_PATTERN: rsp_tready <= ((pattern_count % 11) < 7);
            default:       rsp_tready <= 1'b1;
         endcase
      end
   end

   task automatic send_sample(sample_t s);
      int gap;
      req_tdata <= s;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_loop_results.push_back(advance_loop(s));
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 12);
         gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_loop_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      apply_register(index, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_register(logic [2:0] index);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {index, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      check_field("register readback", register_value(index), csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_loop(logic [31:0] kp, logic [31:0] ki, logic [31:0] nominal,
                               logic [31:0] step, logic [31:0] limit);
      drain_results();
      write_register(REG_KP_GAIN, kp);
      write_register(REG_KI_GAIN, ki);
      write_register(REG_NOMINAL, nominal);
      write_register(REG_TIME_STEP, step);
      write_register(REG_INT_LIMIT, limit);
      check_register(REG_KP_GAIN);
      check_register(REG_KI_GAIN);
      check_register(REG_NOMINAL);
      check_register(REG_TIME_STEP);
      check_register(REG_INT_LIMIT);
   endtask

   // Mostly balanced grid waveforms near the programmed frequency, with phase jumps and noise.
   task automatic send_random_items(int count);
      longint offset;
      offset = longint'($urandom_range(0, 32'h0200_0000)) - 64'sh0100_0000;
      wave_step = 32'(((cfg_nominal * cfg_step) >>> 16) + offset);
      wave_amp = $urandom_range(1000, 32767);
      wave_noise = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2000) : 0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 3) begin
            wave_phase = $urandom;
         end
         if ($urandom_range(0, 99) < 2) begin
            wave_amp = $urandom_range(0, 32767);
         end
         if ($urandom_range(0, 99) < 80) begin
            send_sample(grid_sample());
         end else begin
            send_sample(make_sample(int'($urandom), int'($urandom), int'($urandom)));
         end
      end
   endtask

   task automatic test_register_access();
      check_register(REG_KP_GAIN);
      check_register(REG_KI_GAIN);
      check_register(REG_NOMINAL);
      check_register(REG_TIME_STEP);
      check_register(REG_INT_LIMIT);
      write_register(UNMAPPED_REG, 32'hFFFF_FFFF);
      check_register(REG_KP_GAIN);
      check_register(REG_INT_LIMIT);
   endtask

   task automatic test_directed_cases();
      ready_mode = READY_RANDOM;
      sender_gap_max = 3;
      send_sample(make_sample(0, 0, 0));
      send_sample(make_sample(32767, 32767, 32767));
      send_sample(make_sample(-32768, -32768, -32768));
      send_sample(make_sample(32767, -32768, 32767));
      send_sample(make_sample(-32768, 32767, -32768));
      send_sample(make_sample(0, 32767, -32768));
      send_sample(make_sample(32767, -32768, 32767));
      // Zero time step: phase and integral must stay put.
      program_loop(25600, 256000, 3276800, 0, 1000);
      send_sample(make_sample(12000, -30000, 18000));
      send_sample(make_sample(-32768, 32767, 0));
      send_sample(make_sample(5000, 5000, -10000));
      // Zero integral limit holds the integral at zero.
      program_loop(25600, 256000, 3276800, 4294967, 0);
      send_sample(make_sample(32767, 0, -32768));
      send_sample(make_sample(-20000, 32767, -32768));
      send_sample(make_sample(100, -100, 0));
      // Frequency overflow in both directions.
      program_loop(32'hFF_FFFF, 32'hFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF);
      send_sample(make_sample(-32768, 32767, -32768));
      send_sample(make_sample(32767, -32768, 32767));
      send_sample(make_sample(20000, -25000, 30000));
      send_sample(make_sample(-30000, 10000, 32767));
      // Negative frequency drives the phase backwards through the wrap.
      program_loop(32'hFF_FFFF, 0, 0, 4294967, 1000);
      send_sample(make_sample(32767, -32768, 32767));
      send_sample(make_sample(-32768, 32767, -32768));
      send_sample(make_sample(30000, 0, -30000));
      program_loop(25600, 256000, 3276800, 4294967, 1000);
   endtask

   task automatic test_default_loop();
      ready_mode = READY_RANDOM;
      sender_gap_max = 8;
      send_random_items(500);
   endtask

   task automatic test_register_sweep();
      for (int setting = 0; setting < 6; setting++) begin
         case (setting)
            0: program_loop(0, 0, $urandom_range(0, 32'h7FFF_FFFF), 4294967,
                            $urandom_range(0, 65535));
            1: program_loop(32'hFF_FFFF, 32'hFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 65535);
            2: program_loop($urandom_range(0, 65535), $urandom, 0, 1, 0);
            3: program_loop($urandom, $urandom, $urandom, $urandom, $urandom);
            4: program_loop($urandom_range(0, 100000), $urandom_range(0, 1000000), 3276800,
                            4294967, $urandom_range(1, 2000));
            default: program_loop($urandom_range(0, 32'hFF_FFFF), $urandom_range(0, 65535),
                                  $urandom_range(0, 32'h7FFF_FFFF),
                                  $urandom_range(1, 32'hFF_FFFF), $urandom_range(0, 65535));
         endcase
         ready_mode = (setting == 4) ? READY_ALWAYS : (setting % 2 == 0) ? READY_PATTERN
                                                                          : READY_RANDOM;
         sender_gap_max = (setting == 4) ? 0 : $urandom_range(1, 10);
         send_random_items(200);
      end
      program_loop(25600, 256000, 3276800, 4294967, 1000);
   endtask

   task automatic test_result_backpressure();
      ready_mode = READY_ALWAYS;
      sender_gap_max = 0;
      hold_length = 400;
      hold_requests++;
      send_random_items(60);
      ready_mode = READY_PATTERN;
      send_random_items(40);
   endtask

   task automatic test_sender_pause();
      ready_mode = READY_RANDOM;
      sender_gap_max = 5;
      send_random_items(60);
      drain_results();
      send_random_items(60);
   endtask

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         sine_lut[i] = poly_sine(i);
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_register_access();
      test_directed_cases();
      test_default_loop();
      test_register_sweep();
      test_result_backpressure();
      test_sender_pause();
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
